>>> src/abe_pkg.sv
// Shared opcodes, fault codes, FSM states and control/status bundles of the executor.
package abe_pkg;

	localparam int unsigned DataW  = 8;
	localparam int unsigned FaultW = 2;
	localparam int unsigned InW    = 3 * DataW;
	localparam int unsigned OutW   = 2 * DataW + 2 + FaultW;
	localparam int unsigned OutPadW = ((OutW + 7) / 8) * 8;
	localparam int unsigned DivStepW = $clog2(DataW);

	localparam logic [DataW-1:0] OP_HALT = 8'h00;
	localparam logic [DataW-1:0] OP_LOAD = 8'h01;
	localparam logic [DataW-1:0] OP_INT  = 8'h02;
	localparam logic [DataW-1:0] OP_NOP  = 8'h03;
	localparam logic [DataW-1:0] OP_MUL  = 8'h04;
	localparam logic [DataW-1:0] OP_DIV  = 8'h05;
	localparam logic [DataW-1:0] OP_ADD  = 8'h06;
	localparam logic [DataW-1:0] OP_SUB  = 8'h07;
	localparam logic [DataW-1:0] OP_JUMP = 8'h08;
	localparam logic [DataW-1:0] OP_CALL = 8'h09;
	localparam logic [DataW-1:0] OP_PUSH = 8'h0A;
	localparam logic [DataW-1:0] OP_POP  = 8'h0B;
	localparam logic [DataW-1:0] OP_RET  = 8'h0C;
	localparam logic [DataW-1:0] OP_CMP  = 8'h0D;

	localparam logic [FaultW-1:0] FAULT_NONE    = 2'd0;
	localparam logic [FaultW-1:0] FAULT_DIVZERO = 2'd1;
	localparam logic [FaultW-1:0] FAULT_ILLEGAL = 2'd2;
	localparam logic [FaultW-1:0] FAULT_INT     = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} abe_state_t;

	typedef struct packed {
		logic load_instr;
		logic div_start;
		logic div_step;
		logic commit;
	} abe_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
		logic halted;
	} abe_sts_t;

endpackage

>>> src/abe_ctrl.sv
// Controller state machine: sequences fetch, optional divide and write-back.
module abe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  abe_pkg::abe_sts_t sts,
	output abe_pkg::abe_cmd_t cmd
);
	import abe_pkg::*;

	abe_state_t state_q;
	abe_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = sts.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (sts.div_last) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready       = 1'b1;
				cmd.load_instr = s_tvalid;
			end
			S_EXEC: begin
				cmd.div_start = sts.need_div;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DONE: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/abe_dp.sv
// Datapath: machine registers, ALU, iterative divider and output register.
module abe_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [abe_pkg::InW-1:0]       s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [abe_pkg::OutPadW-1:0]   m_tdata,
	input  abe_pkg::abe_cmd_t             cmd,
	output abe_pkg::abe_sts_t             sts
);
	import abe_pkg::*;

	logic [DataW-1:0]    op_q, a_q, b_q;
	logic [DataW-1:0]    ip_q, acc_q;
	logic                eq_q, stop_q;
	logic [DataW-1:0]    rem_q, quo_q;
	logic [DivStepW-1:0] cnt_q;
	logic                out_valid_q;
	logic [OutW-1:0]     out_q;

	logic [DataW-1:0]    ip_nxt, acc_nxt;
	logic                eq_nxt, stop_nxt;
	logic [FaultW-1:0]   fault_nxt;
	logic [2*DataW-1:0]  product;
	logic [DataW:0]      rem_shift;
	logic [DataW:0]      rem_diff;

	// Hold the fetched instruction for the whole execution.
	always_ff @(posedge clk) begin
		if (cmd.load_instr) begin
			op_q <= s_tdata[DataW-1:0];
			a_q  <= s_tdata[2*DataW-1:DataW];
			b_q  <= s_tdata[3*DataW-1:2*DataW];
		end
	end

	// Restoring divider, one quotient bit per step, MSB first.
	assign rem_shift = {rem_q, quo_q[DataW-1]};
	assign rem_diff  = rem_shift - {1'b0, a_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= acc_q;
		end else if (cmd.div_step) begin
			if (!rem_diff[DataW]) begin
				rem_q <= rem_diff[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign product = acc_q * a_q;

	always_comb begin
		ip_nxt    = ip_q;
		acc_nxt   = acc_q;
		eq_nxt    = eq_q;
		stop_nxt  = stop_q;
		fault_nxt = FAULT_NONE;
		if (stop_q) begin
			fault_nxt = FAULT_ILLEGAL;
		end else begin
			unique case (op_q)
				OP_HALT: begin
					stop_nxt = 1'b1;
					ip_nxt   = ip_q + 8'd1;
				end
				OP_LOAD: begin
					acc_nxt = a_q;
					ip_nxt  = ip_q + 8'd2;
				end
				OP_INT: fault_nxt = FAULT_INT;
				OP_NOP, OP_CALL, OP_PUSH, OP_POP, OP_RET: ip_nxt = ip_q + 8'd1;
				OP_MUL: begin
					acc_nxt = product[DataW-1:0];
					ip_nxt  = ip_q + 8'd2;
				end
				OP_DIV: begin
					if (a_q == '0) begin
						fault_nxt = FAULT_DIVZERO;
					end else begin
						acc_nxt = quo_q;
						ip_nxt  = ip_q + 8'd2;
					end
				end
				OP_ADD: begin
					acc_nxt = acc_q + a_q;
					ip_nxt  = ip_q + 8'd2;
				end
				OP_SUB: begin
					acc_nxt = acc_q - a_q;
					ip_nxt  = ip_q + 8'd2;
				end
				OP_JUMP: ip_nxt = a_q;
				OP_CMP: begin
					eq_nxt = (a_q == b_q);
					ip_nxt = ip_q + 8'd3;
				end
				default: fault_nxt = FAULT_ILLEGAL;
			endcase
		end
	end

	// Machine state advances only on write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q   <= '0;
			acc_q  <= '0;
			eq_q   <= 1'b0;
			stop_q <= 1'b0;
		end else if (cmd.commit) begin
			ip_q   <= ip_nxt;
			acc_q  <= acc_nxt;
			eq_q   <= eq_nxt;
			stop_q <= stop_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {fault_nxt, stop_nxt, eq_nxt, acc_nxt, ip_nxt};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutPadW-OutW){1'b0}}, out_q};

	assign sts.need_div = !stop_q && (op_q == OP_DIV) && (a_q != '0);
	assign sts.div_last = (cnt_q == {DivStepW{1'b1}});
	assign sts.out_free = !out_valid_q || m_tready;
	assign sts.halted   = stop_q;

endmodule

>>> src/accumulator_bytecode_executor_top.sv
// Top level of the accumulator machine instruction executor.
// Sequence: an accepted item is latched in idle, executed, passed through the bit-serial
//   divider for a nonzero divide, and written to the output register once it is free.
// One item is in flight at a time, and the output register lets the next item enter
//   while a result waits.
// Reset: arst_n clears pointer, accumulator, zero flag, halted mark and all control state.
module accumulator_bytecode_executor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata from bit 0: cmd[7:0], operand_first[15:8], operand_second[23:16]
	input  logic [abe_pkg::InW-1:0]       s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata from bit 0: next_address[7:0], accumulator_value[15:8], zero_flag[16],
	// halted[17], fault[19:18], zero fill[23:20]
	output logic [abe_pkg::OutPadW-1:0]   m_tdata
);
	import abe_pkg::*;

	abe_cmd_t cmd;
	abe_sts_t sts;

	// Controller: take an item in idle, run the divider if needed, write back when the
	// output register is free.
	abe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: instruction latch, machine registers, ALU, divider, output item register.
	abe_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// One item at a time: no accept right after an accept.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Never overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("write-back over an untaken result");

	// Halted mark is sticky until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sts.halted))
		else $error("halted mark cleared without reset");

	// Divider only runs from idle through execute.
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.load_instr))
		else $error("divide started without a fresh item");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the accumulator machine instruction executor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import abe_pkg::*;

	localparam int CyclePeriod = 12;
	localparam int ResetCycles = 5;
	localparam int RandomItems = 1950;
	localparam int DrainCycles = 30;      // well past the divide latency
	localparam int CycleLimit  = 1000000;

	// One result item as it leaves the block on m_tdata.
	typedef struct packed {
		logic [FaultW-1:0] fault;
		logic              halted;
		logic              zero_flag;
		logic [DataW-1:0]  accumulator_value;
		logic [DataW-1:0]  next_address;
	} exec_result_t;

	// Tracks the machine state, predicts one result per accepted instruction and
	// compares it with what comes out.
	class exec_scoreboard;
		logic [DataW-1:0] pointer;
		logic [DataW-1:0] acc;
		logic             equal;
		logic             stopped;
		exec_result_t     pending_results[$];
		int               errors;

		function new();
			pointer = '0;
			acc     = '0;
			equal   = 1'b0;
			stopped = 1'b0;
			errors  = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_instr(logic [DataW-1:0] op, logic [DataW-1:0] a,
			logic [DataW-1:0] b);
			exec_result_t     res;
			logic [FaultW-1:0] fault;
			fault = FAULT_NONE;
			if (stopped) begin
				// nothing executes once halted
				fault = FAULT_ILLEGAL;
			end else begin
				case (op)
					OP_HALT: begin
						stopped = 1'b1;
						pointer = pointer + 8'd1;
					end
					OP_LOAD: begin
						acc     = a;
						pointer = pointer + 8'd2;
					end
					OP_INT: fault = FAULT_INT;
					OP_NOP, OP_CALL, OP_PUSH, OP_POP, OP_RET: pointer = pointer + 8'd1;
					OP_MUL: begin
						acc     = acc * a;
						pointer = pointer + 8'd2;
					end
					OP_DIV: begin
						if (a == '0) begin
							fault = FAULT_DIVZERO;
						end else begin
							acc     = acc / a;
							pointer = pointer + 8'd2;
						end
					end
					OP_ADD: begin
						acc     = acc + a;
						pointer = pointer + 8'd2;
					end
					OP_SUB: begin
						acc     = acc - a;
						pointer = pointer + 8'd2;
					end
					OP_JUMP: pointer = a;
					OP_CMP: begin
						equal   = (a == b);
						pointer = pointer + 8'd3;
					end
					default: fault = FAULT_ILLEGAL;
				endcase
			end
			res.next_address      = pointer;
			res.accumulator_value = acc;
			res.zero_flag         = equal;
			res.halted            = stopped;
			res.fault             = fault;
			pending_results.push_back(res);
		endfunction

		task report(string field, int got, int want);
			$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
			errors++;
		endtask

		task check_result(logic [OutPadW-1:0] word);
			exec_result_t got;
			exec_result_t want;
			got = exec_result_t'(word[OutW-1:0]);
			if (pending_results.size() == 0) begin
				report("result with none expected", int'(word), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.next_address != want.next_address)
					report("next_address", got.next_address, want.next_address);
				if (got.accumulator_value != want.accumulator_value)
					report("accumulator_value", got.accumulator_value, want.accumulator_value);
				if (got.zero_flag !== want.zero_flag)
					report("zero_flag", got.zero_flag, want.zero_flag);
				if (got.halted !== want.halted)
					report("halted", got.halted, want.halted);
				if (got.fault != want.fault)
					report("fault", got.fault, want.fault);
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InW-1:0]      s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutPadW-1:0]  m_tdata;

	exec_scoreboard exec_check = new();
	bit             calm = 1'b0;   // set: no idling on either side for a stretch
	int             cycles = 0;

	accumulator_bytecode_executor_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #(CyclePeriod / 2) clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Watch both handshakes: an accepted instruction adds a prediction, an accepted
	// result is checked against the oldest one. Values seen here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				exec_check.note_instr(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
			if (m_tvalid && m_tready)
				exec_check.check_result(m_tdata);
		end
	end

	// Mostly short gaps, a few long ones, none at all during a calm stretch.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Present one instruction and hold it until the block takes it. Valid stays high
	// across back-to-back items so it is never dropped and raised in one step.
	task automatic send_instr(logic [DataW-1:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly legal opcodes other than halt, some unknown ones; operands lean on the
	// extremes, divides by zero show up, and compares often get equal operands.
	task automatic send_random_instr();
		logic [DataW-1:0] op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 90)
			op = DataW'($urandom_range(int'(OP_LOAD), int'(OP_CMP)));
		else
			op = DataW'($urandom_range(int'(OP_CMP) + 1, 255));
		r = $urandom_range(0, 99);
		if (r < 10)
			a = '0;
		else if (r < 20)
			a = '1;
		else if (r < 30)
			a = DataW'($urandom_range(1, 3));
		else
			a = DataW'($urandom);
		if (op == OP_CMP && $urandom_range(0, 99) < 40)
			b = a;
		else
			b = DataW'($urandom);
		send_instr(op, a, b);
	endtask

	// Drive the result side: stall at random, then hold ready until a result is taken.
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: arithmetic wrap, every opcode but halt, each fault kind, pointer wrap.
		send_instr(OP_LOAD, 8'hFF, 8'h00);
		send_instr(OP_ADD,  8'h01, 8'h00);   // 0xFF + 1 wraps to zero
		send_instr(OP_SUB,  8'h01, 8'hFF);   // 0 - 1 wraps to 0xFF
		send_instr(OP_MUL,  8'hFF, 8'h00);   // product truncated to 8 bits
		send_instr(OP_LOAD, 8'd200, 8'h00);
		send_instr(OP_DIV,  8'd7, 8'h00);    // truncating divide
		send_instr(OP_DIV,  8'h00, 8'h00);   // divide by zero: state untouched
		send_instr(OP_DIV,  8'hFF, 8'h00);
		send_instr(OP_LOAD, 8'hFF, 8'h00);
		send_instr(OP_DIV,  8'h01, 8'h00);
		send_instr(OP_INT,  8'h55, 8'hAA);   // unsupported interrupt
		send_instr(OP_NOP,  8'hFF, 8'hFF);
		send_instr(OP_CALL, 8'h12, 8'h34);
		send_instr(OP_PUSH, 8'h00, 8'h00);
		send_instr(OP_POP,  8'hFF, 8'h00);
		send_instr(OP_RET,  8'h00, 8'hFF);
		send_instr(OP_CMP,  8'h05, 8'h05);
		send_instr(OP_CMP,  8'hFF, 8'h00);
		send_instr(OP_CMP,  8'hFF, 8'hFF);
		send_instr(OP_JUMP, 8'hFE, 8'h00);
		send_instr(OP_CMP,  8'h00, 8'h00);   // pointer wraps past 0xFF
		send_instr(OP_JUMP, 8'h00, 8'hFF);
		send_instr(OP_CMP + 8'd1, 8'h00, 8'h00);   // first unknown opcode
		send_instr(8'hFF,   8'hFF, 8'hFF);         // last unknown opcode

		// Random programs, with calm stretches now and then.
		for (int i = 0; i < RandomItems; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_random_instr();
		end
		calm = 1'b0;

		// Halt last: it sticks until reset, so only a few items follow it.
		send_instr(OP_HALT, 8'h00, 8'h00);
		send_instr(OP_HALT, 8'hFF, 8'hFF);
		for (int i = 0; i < 6; i++)
			send_random_instr();
		s_tvalid <= 1'b0;

		while (exec_check.pending() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (exec_check.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
